// ===== hdl/pedal_rest_position_learner_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pedal rest position learner
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef PEDAL_REST_POSITION_LEARNER_MACROS_SVH
`define PEDAL_REST_POSITION_LEARNER_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked on every rising edge, quiet while reset is held
`define PRPL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every rising edge, reset included
`define PRPL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRPL_ASSERT(label, clk, rst_n, prop, msg)
`define PRPL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== hdl/prpl_pkg.sv =====
// ----------------------------------------------------------------------------
// prpl_pkg
// Shared types and constants of the pedal rest position learner.
// ----------------------------------------------------------------------------
`default_nettype none

package prpl_pkg;

    localparam int POS_W      = 16;
    localparam int LRN_W      = 16;
    localparam int TMR_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int STEP_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // sample at or above this is clamped on the downward path
    localparam logic [POS_W-1:0] SAMPLE_CAP = 16'd1024;
    localparam logic [14:0]      LIMIT_CAP  = 15'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_POSITION     = 3'd0,
        CFG_INIT_POSITION    = 3'd1,
        CFG_QUALIFY_DELAY    = 3'd2,
        CFG_STEP_UP          = 3'd3,
        CFG_STEP_DOWN        = 3'd4,
        CFG_INSTANT_MODE     = 3'd5,
        CFG_DEFAULT_POSITION = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] min_position;
        logic [BYTE_W-1:0] init_position;
        logic [TMR_W-1:0]  qualify_delay;
        logic [STEP_W-1:0] step_up;
        logic [STEP_W-1:0] step_down;
        logic              instant_mode;
        logic [BYTE_W-1:0] default_position;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/prpl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// prpl_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module prpl_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [prpl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [prpl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output prpl_pkg::t_cfg                        o_cfg
);
    import prpl_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_POSITION:     n_cfg.min_position     = i_cfg_data[BYTE_W-1:0];
                CFG_INIT_POSITION:    n_cfg.init_position    = i_cfg_data[BYTE_W-1:0];
                CFG_QUALIFY_DELAY:    n_cfg.qualify_delay    = i_cfg_data[TMR_W-1:0];
                CFG_STEP_UP:          n_cfg.step_up          = i_cfg_data[STEP_W-1:0];
                CFG_STEP_DOWN:        n_cfg.step_down        = i_cfg_data[STEP_W-1:0];
                CFG_INSTANT_MODE:     n_cfg.instant_mode     = i_cfg_data[0];
                CFG_DEFAULT_POSITION: n_cfg.default_position = i_cfg_data[BYTE_W-1:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hdl/prpl_qual_timer.sv =====
// ----------------------------------------------------------------------------
// prpl_qual_timer
// Qualification timer: reloads when its condition starts to hold, counts
// down, and fires on every tick spent at zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pedal_rest_position_learner_macros.svh"

module prpl_qual_timer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_run,
    input  wire logic                         i_drop,
    input  wire logic [prpl_pkg::TMR_W-1:0]   i_delay,
    output logic                              o_fire
);
    import prpl_pkg::*;

    logic [TMR_W-1:0] r_timer;
    logic [TMR_W-1:0] n_timer;
    logic             r_active;
    logic             n_active;

    assign o_fire = i_run && r_active && (r_timer == '0);

    always_comb begin
        n_timer  = r_timer;
        n_active = r_active;
        if (i_run) begin
            n_active = 1'b1;
            if (!r_active) begin
                n_timer = i_delay;
            end else if (r_timer != '0) begin
                n_timer = r_timer - 1'b1;
            end
        end else if (i_drop) begin
            // condition lost: timer keeps its count
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer  <= '0;
            r_active <= 1'b0;
        end else begin
            r_timer  <= n_timer;
            r_active <= n_active;
        end
    end

    `PRPL_ASSERT(a_first_tick_reloads, i_clk, i_rst_n, (i_run && !r_active) |=> (r_timer == $past(i_delay)), "timer not reloaded on first tick")
    `PRPL_ASSERT(a_fire_holds_timer, i_clk, i_rst_n, o_fire |=> (r_active && r_timer == '0), "timer moved after firing")
    `PRPL_ASSERT(a_drop_keeps_count, i_clk, i_rst_n, (i_drop && !i_run) |=> (!r_active && $stable(r_timer)), "drop changed timer count")

endmodule

`default_nettype wire

// ===== hdl/prpl_core.sv =====
// ----------------------------------------------------------------------------
// prpl_core
// Learned-position register and the per-sample update decision.
// ----------------------------------------------------------------------------
`default_nettype none

module prpl_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire prpl_pkg::t_cfg               i_cfg,
    input  wire logic                         i_step,
    input  wire logic                         i_mode,
    input  wire logic [prpl_pkg::POS_W-1:0]   i_position,
    input  wire logic                         i_enable,
    output logic      [prpl_pkg::LRN_W-1:0]   o_learned,
    output logic                              o_updated
);
    import prpl_pkg::*;

    logic [LRN_W-1:0] r_learned;
    logic [LRN_W-1:0] n_learned;

    logic [POS_W-1:0]   minq;
    logic [POS_W-1:0]   init4;
    logic [LRN_W-1:0]   min64;
    logic [LRN_W-1:0]   init64;
    logic [LRN_W-1:0]   dflt64;
    logic [POS_W+3:0]   pos16;
    logic               proc;
    logic               below;
    logic               above;
    logic               up_ok;
    logic               down_ok;
    logic               up_fire;
    logic               down_fire;
    logic [LRN_W-1:0]   up_inc;
    logic [LRN_W-1:0]   up_val;
    logic [14:0]        dn_tgt;
    logic signed [16:0] dn_dec;
    logic [14:0]        dn_val;

    assign minq   = {6'd0, i_cfg.min_position, 2'b00};
    assign init4  = {6'd0, i_cfg.init_position, 2'b00};
    assign min64  = {2'b00, i_cfg.min_position, 6'd0};
    assign init64 = {2'b00, i_cfg.init_position, 6'd0};
    assign dflt64 = {2'b00, i_cfg.default_position, 6'd0};
    assign pos16  = {i_position, 4'b0000};

    assign proc    = i_step && !i_mode && i_enable;
    assign below   = i_position < minq;
    assign above   = pos16 > {4'd0, r_learned};
    assign up_ok   = (r_learned < init64) && (i_position < init4);
    assign down_ok = i_position > minq;

    prpl_qual_timer u_up_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (proc && !below && above && up_ok),
        .i_drop  (proc && !below && above && !up_ok),
        .i_delay (i_cfg.qualify_delay),
        .o_fire  (up_fire)
    );

    prpl_qual_timer u_down_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (proc && !below && !above && down_ok),
        .i_drop  (proc && !below && !above && !down_ok),
        .i_delay (i_cfg.qualify_delay),
        .o_fire  (down_fire)
    );

    // upward: min(learned + step, sample*16), both wrapping at 16 bits
    assign up_inc = r_learned + i_cfg.step_up;
    assign up_val = (up_inc < pos16[LRN_W-1:0]) ? up_inc : pos16[LRN_W-1:0];

    // downward: target sample*16 clamped; stepped mode keeps the larger of
    // target and learned - step, the latter limited to the cap
    assign dn_tgt = (i_position >= SAMPLE_CAP) ? LIMIT_CAP : {1'b0, i_position[9:0], 4'b0000};
    assign dn_dec = $signed({1'b0, r_learned}) - $signed({1'b0, i_cfg.step_down});

    always_comb begin
        dn_val = dn_tgt;
        if (!i_cfg.instant_mode && (dn_dec > $signed({2'b00, dn_tgt}))) begin
            if (dn_dec > $signed({2'b00, LIMIT_CAP})) begin
                dn_val = LIMIT_CAP;
            end else begin
                dn_val = dn_dec[14:0];
            end
        end
    end

    always_comb begin
        n_learned = r_learned;
        o_updated = 1'b0;
        if (i_step) begin
            priority if (i_mode) begin
                n_learned = dflt64;
                o_updated = 1'b1;
            end else if (!i_enable) begin
                n_learned = r_learned;
            end else if (below) begin
                n_learned = min64;
                o_updated = 1'b1;
            end else if (up_fire) begin
                n_learned = up_val;
                o_updated = 1'b1;
            end else if (down_fire) begin
                n_learned = {1'b0, dn_val};
                o_updated = 1'b1;
            end else begin
                // timer still qualifying or path condition lost
                n_learned = r_learned;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learned <= '0;
        end else begin
            r_learned <= n_learned;
        end
    end

    assign o_learned = n_learned;

endmodule

`default_nettype wire

// ===== hdl/pedal_rest_position_learner.sv =====
// Path: input register, then result register holding the updated value.
// Throughput: one sample per cycle unless the output stalls; the learned
// value is updated in the same cycle that reads it, so consecutive samples
// follow without a gap.
// Reset (synchronous, active low) clears the learned value, both timers,
// the configuration registers and both valid flags.
// ----------------------------------------------------------------------------
// pedal_rest_position_learner
// Learns the released-pedal position from filtered pedal samples.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pedal_rest_position_learner_macros.svh"

module pedal_rest_position_learner (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [prpl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [prpl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_mode,
    input  wire logic [prpl_pkg::POS_W-1:0]       i_position,
    input  wire logic                             i_enable,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic      [prpl_pkg::LRN_W-1:0]       o_learned_position,
    output logic                                  o_updated
);
    import prpl_pkg::*;

    t_cfg cfg;

    logic             r_in_valid;
    logic             r_mode;
    logic [POS_W-1:0] r_position;
    logic             r_enable;
    logic             r_out_valid;
    logic [LRN_W-1:0] r_learned;
    logic             r_updated;
    logic             out_free;
    logic             advance;
    logic [LRN_W-1:0] core_learned;
    logic             core_updated;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    prpl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    prpl_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_step     (advance),
        .i_mode     (r_mode),
        .i_position (r_position),
        .i_enable   (r_enable),
        .o_learned  (core_learned),
        .o_updated  (core_updated)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode     <= i_mode;
            r_position <= i_position;
            r_enable   <= i_enable;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_learned <= core_learned;
            r_updated <= core_updated;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_learned_position = r_learned;
    assign o_updated          = r_updated;

    `PRPL_ASSERT(a_advance_fills_out, i_clk, i_rst_n, advance |=> r_out_valid, "sample lost between stages")
    `PRPL_ASSERT(a_stalled_item_kept, i_clk, i_rst_n, (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_position) && $stable(r_mode)), "stalled sample dropped")
    `PRPL_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> (!r_in_valid && !r_out_valid), "stages not empty after reset")

endmodule

`default_nettype wire

// ===== tb/tb_pedal_rest_position_learner.sv =====
// ----------------------------------------------------------------------------
// tb_pedal_rest_position_learner
// Self-checking bench for the pedal rest position learner. A short directed
// table is followed by bursts of random samples over several register
// settings. Every result is compared with the table or an in-bench model
// of the learner; in most phases both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_pedal_rest_position_learner;
    import prpl_pkg::*;

    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_RESTORE = 1'b1;
    localparam int   DRAIN_CYCLES = 8;
    localparam int   MAX_REPORTS  = 10;
    localparam int   HOLD_CYCLES  = 80;
    localparam int   NUM_PHASES   = 10;

    typedef struct packed {
        logic [LRN_W-1:0] learned;
        logic             updated;
    } rest_result_t;

    typedef struct packed {
        logic             mode;
        logic [POS_W-1:0] position;
        logic             enable;
        logic             typed;
        logic [LRN_W-1:0] exp_learned;
        logic             exp_updated;
    } sample_row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  mode      = 1'b0;
    logic [POS_W-1:0]      position  = '0;
    logic                  enable    = 1'b0;
    logic                  out_ready = 1'b0;
    wire                   in_ready;
    wire                   out_valid;
    wire  [LRN_W-1:0]      learned_position;
    wire                   updated;

    // in-bench model of the learner
    t_cfg              cfg_shadow = '0;
    logic [LRN_W-1:0]  rest_est   = '0;
    logic [TMR_W-1:0]  up_tmr     = '0;
    logic [TMR_W-1:0]  dn_tmr     = '0;
    logic              up_run     = 1'b0;
    logic              dn_run     = 1'b0;

    rest_result_t      pending_q[$];
    sample_row_t       dir_rows[20];

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int writes_seen  = 0;
    int mismatches   = 0;
    int hold_left    = 0;

    pedal_rest_position_learner uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_mode             (mode),
        .i_position         (position),
        .i_enable           (enable),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_learned_position (learned_position),
        .o_updated          (updated)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb_pedal_rest_position_learner failed");
        $finish;
    end

    // reload on the first tick of a condition, count down, fire on every tick at zero
    function automatic logic qualify_tick(inout logic run, inout logic [TMR_W-1:0] tmr);
        logic fire;
        fire = 1'b0;
        if (!run) begin
            tmr = cfg_shadow.qualify_delay;
        end else if (tmr != '0) begin
            tmr = tmr - 1'b1;
        end else begin
            fire = 1'b1;
        end
        run = 1'b1;
        return fire;
    endfunction

    function automatic rest_result_t learn_step(input logic m, input logic [POS_W-1:0] p,
                                                input logic en);
        rest_result_t r;
        int minq;
        int pos16;
        int tgt;
        int inc;
        int dec;
        r.updated = 1'b0;
        if (m == MODE_RESTORE) begin
            rest_est  = LRN_W'(int'(cfg_shadow.default_position) * 64);
            r.updated = 1'b1;
        end else if (en) begin
            minq  = int'(cfg_shadow.min_position) * 4;
            pos16 = int'(p) * 16;
            if (int'(p) < minq) begin
                rest_est  = LRN_W'(minq * 16);
                r.updated = 1'b1;
            end else if (pos16 > int'(rest_est)) begin
                if (int'(rest_est) < int'(cfg_shadow.init_position) * 64 &&
                    int'(p) < int'(cfg_shadow.init_position) * 4) begin
                    if (qualify_tick(up_run, up_tmr)) begin
                        tgt = pos16 & 'hFFFF;
                        inc = (int'(rest_est) + int'(cfg_shadow.step_up)) & 'hFFFF;
                        if (inc < tgt) tgt = inc;
                        rest_est  = LRN_W'(tgt);
                        r.updated = 1'b1;
                    end
                end else begin
                    up_run = 1'b0;
                end
            end else if (int'(p) > minq) begin
                if (qualify_tick(dn_run, dn_tmr)) begin
                    tgt = (p >= SAMPLE_CAP) ? int'(LIMIT_CAP) : pos16;
                    if (!cfg_shadow.instant_mode) begin
                        // signed difference, may go negative
                        dec = int'(rest_est) - int'(cfg_shadow.step_down);
                        if (dec > tgt) tgt = (dec > int'(LIMIT_CAP)) ? int'(LIMIT_CAP) : dec;
                    end
                    rest_est  = LRN_W'(tgt);
                    r.updated = 1'b1;
                end
            end else begin
                dn_run = 1'b0;
            end
        end
        r.learned = rest_est;
        return r;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_MIN_POSITION:     cfg_shadow.min_position     = val[BYTE_W-1:0];
            CFG_INIT_POSITION:    cfg_shadow.init_position    = val[BYTE_W-1:0];
            CFG_QUALIFY_DELAY:    cfg_shadow.qualify_delay    = val[TMR_W-1:0];
            CFG_STEP_UP:          cfg_shadow.step_up          = val[STEP_W-1:0];
            CFG_STEP_DOWN:        cfg_shadow.step_down        = val[STEP_W-1:0];
            CFG_INSTANT_MODE:     cfg_shadow.instant_mode     = val[0];
            CFG_DEFAULT_POSITION: cfg_shadow.default_position = val[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(CFG_MIN_POSITION,     CFG_DATA_W'(c.min_position));
        write_reg(CFG_INIT_POSITION,    CFG_DATA_W'(c.init_position));
        write_reg(CFG_QUALIFY_DELAY,    CFG_DATA_W'(c.qualify_delay));
        write_reg(CFG_STEP_UP,          c.step_up);
        write_reg(CFG_STEP_DOWN,        c.step_down);
        write_reg(CFG_INSTANT_MODE,     CFG_DATA_W'(c.instant_mode));
        write_reg(CFG_DEFAULT_POSITION, CFG_DATA_W'(c.default_position));
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic m, input logic [POS_W-1:0] p, input logic en,
                               input logic typed, input rest_result_t typed_res);
        int gap;
        rest_result_t r;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        position <= p;
        enable   <= en;
        do @(posedge clk); while (!in_ready);
        r = learn_step(m, p, en);
        pending_q.push_back(typed ? typed_res : r);
        samples_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // bursts of samples, mostly around one operating point, so the qualify timers can run out
    task automatic run_bursts(input int budget);
        int left;
        int len;
        int kind;
        int base;
        int lo;
        int hi;
        int pv;
        int minq;
        int est;
        logic m;
        logic en;
        left = budget;
        while (left > 0) begin
            kind = $urandom_range(0, 9);
            minq = int'(cfg_shadow.min_position) * 4;
            est  = int'(rest_est) / 16;
            len  = $urandom_range(1, int'(cfg_shadow.qualify_delay) + 8);
            if (len > left) len = left;
            case (kind)
                1: base = minq + int'($urandom_range(0, 6)) - 3;
                2, 3: begin
                    lo   = est + 1;
                    hi   = int'(cfg_shadow.init_position) * 4 - 1;
                    base = (hi >= lo) ? int'($urandom_range(lo, hi)) : int'($urandom_range(0, 1100));
                end
                4, 5: begin
                    lo   = minq + 1;
                    hi   = est;
                    base = (hi >= lo) ? int'($urandom_range(lo, hi)) : int'($urandom_range(0, 1100));
                end
                6: base = 1000 + int'($urandom_range(0, 100));
                default: base = $urandom_range(0, 1100);
            endcase
            repeat (len) begin
                if (kind == 0) begin
                    // noise
                    m  = ($urandom_range(0, 9) == 0) ? MODE_RESTORE : MODE_SAMPLE;
                    pv = $urandom_range(0, 65535);
                    en = 1'($urandom_range(0, 1));
                end else begin
                    m  = ($urandom_range(0, 99) == 0) ? MODE_RESTORE : MODE_SAMPLE;
                    pv = base + int'($urandom_range(0, 4)) - 2;
                    if (pv < 0) pv = 0;
                    if (pv > 65535) pv = 65535;
                    en = ($urandom_range(0, 99) >= 5);
                end
                send_sample(m, POS_W'(pv), en, 1'b0, '0);
            end
            left -= len;
        end
    endtask

    // result side: check, random back-pressure, occasional long hold-off
    always @(posedge clk) begin : result_side
        rest_result_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (updated) writes_seen++;
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: learned %0d updated %0b",
                                 learned_position, updated);
                end else begin
                    want = pending_q.pop_front();
                    if (learned_position !== want.learned || updated !== want.updated) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("result %0d: expected learned %0d updated %0b, got %0d %0b",
                                     results_seen, want.learned, want.updated,
                                     learned_position, updated);
                    end
                end
                if (results_seen == 150 || results_seen == 600 || results_seen == 1100)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        t_cfg         c;
        rest_result_t typed_res;
        int           budget;

        // directed rows, settings: min 10, init 100, no delay, up 100, down 50, default 20
        dir_rows = '{
            '{MODE_SAMPLE,  16'd0,      1'b0, 1'b1, 16'd0,    1'b0},  // disabled after reset
            '{MODE_RESTORE, 16'hFFFF,   1'b0, 1'b1, 16'd1280, 1'b1},  // restore ignores enable
            '{MODE_SAMPLE,  16'd5,      1'b1, 1'b1, 16'd640,  1'b1},  // below minimum
            '{MODE_SAMPLE,  16'hFFFF,   1'b0, 1'b1, 16'd640,  1'b0},  // disabled
            '{MODE_SAMPLE,  16'd200,    1'b1, 1'b0, 16'd0,    1'b0},  // upward timer start
            '{MODE_SAMPLE,  16'd200,    1'b1, 1'b0, 16'd0,    1'b0},
            '{MODE_SAMPLE,  16'd200,    1'b1, 1'b0, 16'd0,    1'b0},
            '{MODE_SAMPLE,  16'hFFFF,   1'b1, 1'b0, 16'd0,    1'b0},  // above init, up path drops
            '{MODE_SAMPLE,  16'd200,    1'b1, 1'b0, 16'd0,    1'b0},
            '{MODE_SAMPLE,  16'd200,    1'b1, 1'b0, 16'd0,    1'b0},
            '{MODE_RESTORE, 16'd0,      1'b1, 1'b1, 16'd1280, 1'b1},
            '{MODE_SAMPLE,  16'd40,     1'b1, 1'b0, 16'd0,    1'b0},  // at minimum, no down step
            '{MODE_SAMPLE,  16'd50,     1'b1, 1'b0, 16'd0,    1'b0},  // downward timer start
            '{MODE_SAMPLE,  16'd50,     1'b1, 1'b0, 16'd0,    1'b0},
            '{MODE_SAMPLE,  16'd50,     1'b1, 1'b0, 16'd0,    1'b0},
            '{MODE_SAMPLE,  16'd41,     1'b1, 1'b0, 16'd0,    1'b0},
            '{MODE_SAMPLE,  16'd39,     1'b1, 1'b1, 16'd640,  1'b1},
            '{MODE_SAMPLE,  16'h8000,   1'b0, 1'b1, 16'd640,  1'b0},
            '{MODE_SAMPLE,  16'd399,    1'b1, 1'b0, 16'd0,    1'b0},  // up flag kept over restore
            '{MODE_SAMPLE,  16'd400,    1'b1, 1'b0, 16'd0,    1'b0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 25;
        rx_idle_pct = 57;
        c = '0;
        c.min_position     = 8'd10;
        c.init_position    = 8'd100;
        c.qualify_delay    = 8'd0;
        c.step_up          = 16'd100;
        c.step_down        = 16'd50;
        c.instant_mode     = 1'b0;
        c.default_position = 8'd20;
        load_settings(c);
        foreach (dir_rows[k]) begin
            typed_res.learned = dir_rows[k].exp_learned;
            typed_res.updated = dir_rows[k].exp_updated;
            send_sample(dir_rows[k].mode, dir_rows[k].position, dir_rows[k].enable,
                        dir_rows[k].typed, typed_res);
        end
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 4) begin
                tx_idle_pct = 25;
                rx_idle_pct = 57;
            end else if (ph < 7) begin
                tx_idle_pct = 57;
                rx_idle_pct = 25;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            budget = 150;
            case (ph)
                0: begin
                    c = '0;
                    budget = 60;
                end
                1: c = '{min_position: 8'd10, init_position: 8'd200, qualify_delay: 8'd2,
                         step_up: 16'd64, step_down: 16'd32, instant_mode: 1'b0,
                         default_position: 8'd50};
                2: begin
                    c = '{min_position: 8'd255, init_position: 8'd255, qualify_delay: 8'd255,
                          step_up: 16'hFFFF, step_down: 16'hFFFF, instant_mode: 1'b1,
                          default_position: 8'd255};
                    budget = 60;
                end
                3: begin
                    // longest qualify delay with reachable paths
                    c = '{min_position: 8'd2, init_position: 8'd250, qualify_delay: 8'd255,
                          step_up: 16'd1000, step_down: 16'hFFFF, instant_mode: 1'b0,
                          default_position: 8'd0};
                    budget = 270;
                end
                4: c = '{min_position: 8'd5, init_position: 8'd255, qualify_delay: 8'd0,
                         step_up: 16'hFFFF, step_down: 16'd0, instant_mode: 1'b0,
                         default_position: 8'd100};
                5: c = '{min_position: 8'd20, init_position: 8'd150, qualify_delay: 8'd3,
                         step_up: 16'd200, step_down: 16'd500, instant_mode: 1'b1,
                         default_position: 8'd10};
                default: begin
                    c.min_position     = BYTE_W'($urandom_range(0, 60));
                    c.init_position    = BYTE_W'($urandom_range(0, 255));
                    c.qualify_delay    = TMR_W'($urandom_range(0, 6));
                    c.step_up          = STEP_W'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                                      : $urandom_range(0, 300));
                    c.step_down        = STEP_W'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                                      : $urandom_range(0, 300));
                    c.instant_mode     = 1'($urandom_range(0, 1));
                    c.default_position = BYTE_W'($urandom_range(0, 255));
                end
            endcase
            load_settings(c);
            run_bursts(budget);
            wait_drained();
        end

        $display("covered %0d samples over %0d register settings with random stalls",
                 samples_sent, NUM_PHASES + 1);
        $display("%0d results checked, %0d of them wrote the learned position, %0d mismatches",
                 results_seen, writes_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb_pedal_rest_position_learner passed");
        end else begin
            $display("tb_pedal_rest_position_learner failed");
        end
        $finish;
    end

endmodule
